// File: hdl/tcp_sender_window_retransmit_core_macros.svh
// Assertion macros for the TCP sender core.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef TCP_SENDER_WINDOW_RETRANSMIT_CORE_MACROS_SVH
`define TCP_SENDER_WINDOW_RETRANSMIT_CORE_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define TSWR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet during reset.
`define TSWR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/tswr_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the TCP sender core.
// No dependencies; the interfaces, sequencer, datapath and top level import this package.
package tswr_pkg;

    localparam int MAX_PAYLOAD_DEF = 1452;
    localparam int FIFO_DEPTH_DEF  = 64;
    localparam int RESULT_CAP      = 48;
    localparam int NRES_W          = $clog2(RESULT_CAP + 1);

    localparam int SEQ_W   = 48;
    localparam int WSEQ_W  = 32;
    localparam int FLIGHT_W = 17;
    localparam int LEN_OUT_W = 11;

    // Operation codes of an input word.
    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_END   = 3'd1;
    localparam logic [2:0] OP_FILL  = 3'd2;
    localparam logic [2:0] OP_ACK   = 3'd3;
    localparam logic [2:0] OP_TICK  = 3'd4;
    localparam logic [2:0] OP_EMPTY = 3'd5;

    // Result kinds.
    localparam logic [1:0] KIND_STATUS = 2'd0;
    localparam logic [1:0] KIND_NEW    = 2'd1;
    localparam logic [1:0] KIND_RETX   = 2'd2;
    localparam logic [1:0] KIND_EMPTY  = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ISN = 2'd0;
    localparam logic [1:0] CFG_RTO = 2'd1;
    localparam logic [1:0] CFG_CAP = 2'd2;

    localparam logic [15:0] RTO_RESET = 16'd1000;
    localparam logic [15:0] CAP_RESET = 16'd4096;
    localparam logic [WSEQ_W-1:0] HALF_SPAN = 32'h8000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ACK_CMP,
        S_ACK_RET,
        S_ACK_UPD,
        S_FILL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]           kind;
        logic [WSEQ_W-1:0]    seg_seqno;
        logic                 syn_flag;
        logic                 fin_flag;
        logic [LEN_OUT_W-1:0] payload_length;
        logic [SEQ_W-1:0]     stream_offset;
        logic [FLIGHT_W-1:0]  outstanding;
        logic [7:0]           retx_count;
        logic [15:0]          accepted_bytes;
        logic                 last;
    } t_res;

    typedef struct packed {
        logic take_in;
        logic exec;
        logic ack_ret;
        logic ack_upd;
        logic fill_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       ack_ok;
        logic       ack_more;
        logic       fill_go;
        logic       fill_end;
        logic       fill_stall;
        logic       out_room;
        logic       fifo_full;
    } t_sts;

endpackage

// File: hdl/tswr_in_if.sv
`timescale 1ns / 1ps
// Input word channel: event op and its operands.
// Depends on tswr_pkg.
interface tswr_in_if import tswr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] byte_count;
    logic [31:0] ack_number;
    logic [15:0] adv_window;
    logic [15:0] elapsed_ms;

    modport source (output valid, op, byte_count, ack_number, adv_window, elapsed_ms,
                    input ready);
    modport sink (input valid, op, byte_count, ack_number, adv_window, elapsed_ms,
                  output ready);
endinterface

// File: hdl/tswr_out_if.sv
`timescale 1ns / 1ps
// Result word channel: segment descriptors and status words.
// Depends on tswr_pkg.
interface tswr_out_if import tswr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [WSEQ_W-1:0]    seg_seqno;
    logic                 syn_flag;
    logic                 fin_flag;
    logic [LEN_OUT_W-1:0] payload_length;
    logic [SEQ_W-1:0]     stream_offset;
    logic [FLIGHT_W-1:0]  outstanding;
    logic [7:0]           retx_count;
    logic [15:0]          accepted_bytes;
    logic                 last;

    modport source (output valid, kind, seg_seqno, syn_flag, fin_flag, payload_length,
                    stream_offset, outstanding, retx_count, accepted_bytes, last,
                    input ready);
    modport sink (input valid, kind, seg_seqno, syn_flag, fin_flag, payload_length,
                  stream_offset, outstanding, retx_count, accepted_bytes, last,
                  output ready);
endinterface

// File: hdl/tswr_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tswr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/tswr_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the TCP sender: walks each word through its steps.
// Depends on tswr_pkg; drives the datapath through t_cmd.
module tswr_ctrl import tswr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);
    t_state r_state, n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_sts.op == OP_FILL) n_state = S_FILL;
                else if (i_sts.op == OP_ACK) n_state = S_ACK_CMP;
                else n_state = S_FIN;
            end
            S_ACK_CMP: begin
                n_state = i_sts.ack_ok ? S_ACK_RET : S_FIN;
            end
            S_ACK_RET: begin
                if (!i_sts.ack_more) n_state = S_ACK_UPD;
            end
            S_ACK_UPD: begin
                n_state = S_FILL;
            end
            S_FILL: begin
                if (!i_sts.fill_stall && i_sts.fill_end) n_state = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_room) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take_in = i_in_valid;
            end
            S_EXEC:    o_cmd.exec = 1'b1;
            S_ACK_CMP: o_cmd = '0;
            S_ACK_RET: o_cmd.ack_ret = i_sts.ack_more;
            S_ACK_UPD: o_cmd.ack_upd = 1'b1;
            S_FILL:    o_cmd.fill_step = !i_sts.fill_stall;
            S_FIN:     o_cmd.finish = i_sts.out_room;
            default:   o_cmd = '0;
        endcase
    end
endmodule

// File: hdl/tswr_dp.sv
`timescale 1ns / 1ps
// Datapath of the TCP sender: sequence state, timer, segment queue, result staging.
// Depends on tswr_pkg and tswr_ram; steered by t_cmd from tswr_ctrl.
module tswr_dp import tswr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_byte_count,
    input  logic [31:0] i_ack_number,
    input  logic [15:0] i_adv_window,
    input  logic [15:0] i_elapsed_ms,
    input  logic        i_out_ready,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    output logic        o_out_valid,
    output t_res        o_out
);
    localparam int IDX_W = $clog2(FIFO_DEPTH);
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
    localparam int ENT_W = SEQ_W + LEN_W + 2;
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(FIFO_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FIFO_DEPTH - 1);
    localparam logic [FLIGHT_W-1:0] MAXP_C = FLIGHT_W'(MAX_PAYLOAD);

    // Captured word and configuration.
    logic [2:0]  r_op;
    logic [15:0] r_cnt, r_wsize, r_ms, r_acc;
    logic [31:0] r_ackno, r_isn;
    logic [15:0] r_irto, r_cap;

    // Sender state.
    logic [SEQ_W-1:0]    r_next;
    logic [IDX_W-1:0]    r_head, r_tail;
    logic [CNT_W-1:0]    r_count;
    logic [FLIGHT_W-1:0] r_flight;
    logic [15:0]         r_buf, r_win;
    logic                r_ended, r_fin_done, r_ton, r_removed;
    logic [31:0]         r_elapsed, r_rto;
    logic [7:0]          r_retx;
    logic [SEQ_W:0]      r_ack;
    logic [NRES_W-1:0]   r_nres;
    t_res                r_stg, r_out;
    logic                r_stg_v, r_out_v;

    // Queue entry read at the head.
    logic [ENT_W-1:0] ram_rdata, ram_wdata;
    logic [IDX_W-1:0] ram_raddr, head_inc, tail_inc;
    logic [SEQ_W-1:0] e_seq;
    logic [LEN_W-1:0] e_len;
    logic             e_syn, e_fin;
    logic [FLIGHT_W-1:0] e_space;

    assign {e_seq, e_len, e_syn, e_fin} = ram_rdata;
    assign e_space  = FLIGHT_W'(e_len) + FLIGHT_W'(e_syn) + FLIGHT_W'(e_fin);
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign ram_raddr = i_cmd.ack_ret ? head_inc : r_head;

    // Fill step decision.
    logic [FLIGHT_W-1:0] win, avail, pl, f_len, f_space;
    logic                cnt_ok, f_go, f_end, f_syn, f_fin;
    logic [15:0]         buf_rem;

    always_comb begin
        win     = (r_win == '0) ? FLIGHT_W'(1) : FLIGHT_W'(r_win);
        cnt_ok  = (r_count < DEPTH_C) && (r_nres < NRES_W'(RESULT_CAP));
        avail   = win - r_flight;
        pl      = MAXP_C;
        if (FLIGHT_W'(r_buf) < pl) pl = FLIGHT_W'(r_buf);
        if (avail < pl) pl = avail;
        buf_rem = r_buf - pl[15:0];
        f_go = 1'b0; f_end = 1'b1; f_syn = 1'b0; f_fin = 1'b0; f_len = '0;
        if (r_next == '0) begin
            f_go  = cnt_ok;
            f_syn = 1'b1;
        end else if (r_flight < win && cnt_ok) begin
            if (pl == '0) begin
                f_go  = r_ended && (r_buf == '0) && !r_fin_done;
                f_fin = 1'b1;
            end else begin
                f_go  = 1'b1;
                f_len = pl;
                f_fin = r_ended && (buf_rem == '0) && !r_fin_done && (avail > pl);
                f_end = f_fin;
            end
        end
        f_space = f_len + FLIGHT_W'(f_syn) + FLIGHT_W'(f_fin);
    end

    assign ram_wdata = {r_next, LEN_W'(f_len), f_syn, f_fin};

    // Ack unwrapping and write room.
    logic [31:0]    off;
    logic [SEQ_W-1:0] base;
    logic [SEQ_W:0] ack_abs;
    logic [15:0]    room, acc;

    always_comb begin
        off  = r_ackno - r_isn;
        base = {r_next[SEQ_W-1:WSEQ_W], off};
        ack_abs = {1'b0, base};
        if (base > r_next) begin
            if ((base - r_next) > SEQ_W'(HALF_SPAN) && r_next[SEQ_W-1:WSEQ_W] != '0)
                ack_abs = {1'b0, base} - (SEQ_W+1)'(64'h1_0000_0000);
        end else if ((r_next - base) > SEQ_W'(HALF_SPAN)) begin
            ack_abs = {1'b0, base} + (SEQ_W+1)'(64'h1_0000_0000);
        end
        room = (!r_ended && r_cap > r_buf) ? r_cap - r_buf : '0;
        acc  = (r_cnt < room) ? r_cnt : room;
    end

    // Timer step.
    logic [32:0] t_sum;
    logic [31:0] t_sat, rto_dbl;
    logic        t_fire;
    logic [7:0]  retx_new;

    always_comb begin
        t_sum   = {1'b0, r_elapsed} + 33'(r_ms);
        t_sat   = t_sum[32] ? '1 : t_sum[31:0];
        t_fire  = r_ton && (r_count != '0) && (t_sat >= r_rto);
        rto_dbl = r_rto[31] ? '1 : {r_rto[30:0], 1'b0};
        retx_new = r_retx;
        if (r_win != '0 && r_retx != 8'hFF) retx_new = r_retx + 8'd1;
    end

    // Result words.
    logic   out_room, push, emit;
    t_res   res_new, res_stat, stg_last;

    assign out_room = !r_out_v || i_out_ready;
    assign push     = i_cmd.fill_step && f_go;

    always_comb begin
        res_new = '0;
        emit    = 1'b0;
        if (push) begin
            emit = 1'b1;
            res_new.kind           = KIND_NEW;
            res_new.seg_seqno      = r_next[WSEQ_W-1:0] + r_isn;
            res_new.syn_flag       = f_syn;
            res_new.fin_flag       = f_fin;
            res_new.payload_length = LEN_OUT_W'(f_len);
            res_new.stream_offset  = (r_next == '0) ? '0 : r_next - 1'b1;
            res_new.outstanding    = r_flight + f_space;
            res_new.retx_count     = r_retx;
        end else if (i_cmd.exec && r_op == OP_TICK && t_fire) begin
            emit = 1'b1;
            res_new.kind           = KIND_RETX;
            res_new.seg_seqno      = e_seq[WSEQ_W-1:0] + r_isn;
            res_new.syn_flag       = e_syn;
            res_new.fin_flag       = e_fin;
            res_new.payload_length = LEN_OUT_W'(e_len);
            res_new.stream_offset  = (e_seq == '0) ? '0 : e_seq - 1'b1;
            res_new.outstanding    = r_flight;
            res_new.retx_count     = retx_new;
        end else if (i_cmd.exec && r_op == OP_EMPTY) begin
            emit = 1'b1;
            res_new.kind      = KIND_EMPTY;
            res_new.seg_seqno = r_next[WSEQ_W-1:0] + r_isn;
            res_new.outstanding = r_flight;
            res_new.retx_count = r_retx;
        end
        res_stat = '0;
        res_stat.kind           = KIND_STATUS;
        res_stat.seg_seqno      = r_next[WSEQ_W-1:0] + r_isn;
        res_stat.outstanding    = r_flight;
        res_stat.retx_count     = r_retx;
        res_stat.accepted_bytes = r_acc;
        res_stat.last           = 1'b1;
        // The staged word closes its input when it moves out at finish.
        stg_last      = r_stg;
        stg_last.last = 1'b1;
    end

    // Segment queue memory.
    tswr_ram #(.WIDTH(ENT_W), .DEPTH(FIFO_DEPTH)) u_ram (
        .i_clk   (i_clk),
        .i_we    (push),
        .i_waddr (r_tail),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Captured word and configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_isn  <= '0;
            r_irto <= RTO_RESET;
            r_cap  <= CAP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_ISN: r_isn  <= i_cfg_wdata;
                CFG_RTO: r_irto <= i_cfg_wdata[15:0];
                CFG_CAP: r_cap  <= i_cfg_wdata[15:0];
                default: r_isn  <= r_isn;
            endcase
        end
        if (i_cmd.take_in) begin
            r_op    <= i_op;
            r_cnt   <= i_byte_count;
            r_ackno <= i_ack_number;
            r_wsize <= i_adv_window;
            r_ms    <= i_elapsed_ms;
        end
    end

    // Sender state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next <= '0; r_head <= '0; r_tail <= '0; r_count <= '0;
            r_flight <= '0; r_buf <= '0; r_win <= 16'd1;
            r_ended <= 1'b0; r_fin_done <= 1'b0; r_ton <= 1'b0; r_removed <= 1'b0;
            r_elapsed <= '0; r_rto <= 32'(RTO_RESET); r_retx <= '0;
            r_acc <= '0; r_ack <= '0;
        end else begin
            if (i_cmd.take_in) begin
                r_acc <= '0;
                r_removed <= 1'b0;
            end
            if (i_cmd.exec) begin
                case (r_op)
                    OP_WRITE: begin
                        r_acc <= acc;
                        r_buf <= r_buf + acc;
                    end
                    OP_END: r_ended <= 1'b1;
                    OP_ACK: r_ack <= ack_abs;
                    OP_TICK: begin
                        if (r_ton) begin
                            if (r_count == '0) begin
                                r_ton <= 1'b0;
                            end else if (t_fire) begin
                                r_elapsed <= '0;
                                r_retx <= retx_new;
                                if (r_win != '0) r_rto <= rto_dbl;
                            end else begin
                                r_elapsed <= t_sat;
                            end
                        end
                    end
                    default: r_acc <= r_acc;
                endcase
            end
            // Retire one fully acknowledged segment.
            if (i_cmd.ack_ret) begin
                r_flight  <= (r_flight >= e_space) ? r_flight - e_space : '0;
                r_head    <= head_inc;
                r_count   <= r_count - 1'b1;
                r_removed <= 1'b1;
            end
            if (i_cmd.ack_upd) begin
                if (r_removed) begin
                    r_retx    <= '0;
                    r_rto     <= 32'(r_irto);
                    r_elapsed <= '0;
                    r_ton     <= (r_count != '0);
                end
                r_win <= r_wsize;
            end
            // Send one new segment.
            if (push) begin
                r_tail   <= tail_inc;
                r_count  <= r_count + 1'b1;
                r_flight <= r_flight + f_space;
                r_next   <= r_next + SEQ_W'(f_space);
                if (f_len != '0) r_buf <= buf_rem;
                if (f_fin) r_fin_done <= 1'b1;
                if (!r_ton) begin
                    r_ton     <= 1'b1;
                    r_elapsed <= '0;
                    r_rto     <= 32'(r_irto);
                end
            end
        end
    end

    // Staging word and output register; the staged word learns its last flag late.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_v <= 1'b0;
            r_out_v <= 1'b0;
            r_nres  <= '0;
        end else begin
            if (i_cmd.take_in) r_nres <= '0;
            if (emit) begin
                r_stg   <= res_new;
                r_stg_v <= 1'b1;
                r_nres  <= r_nres + 1'b1;
            end
            if (i_cmd.finish) r_stg_v <= 1'b0;
            // The output register loads at finish or when a new word pushes the staged one.
            if (i_cmd.finish) begin
                r_out_v <= 1'b1;
                r_out   <= r_stg_v ? stg_last : res_stat;
            end else if (emit && r_stg_v) begin
                r_out_v <= 1'b1;
                r_out   <= r_stg;
            end else if (r_out_v && i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    // Status to the sequencer.
    always_comb begin
        o_sts.op         = r_op;
        o_sts.ack_ok     = (r_ack <= {1'b0, r_next});
        o_sts.ack_more   = (r_count != '0) &&
                           (({1'b0, e_seq} + (SEQ_W+1)'(e_space)) <= r_ack);
        o_sts.fill_go    = f_go;
        o_sts.fill_end   = f_end;
        o_sts.fill_stall = f_go && r_stg_v && !out_room;
        o_sts.out_room   = out_room;
        o_sts.fifo_full  = (r_count == DEPTH_C);
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;
endmodule

// File: hdl/tcp_sender_window_retransmit_core.sv
`timescale 1ns / 1ps
// Channel   Dir  Role
// i_in      in   event words: write, end, fill, ack, tick, empty segment
// o_out     out  segment descriptors and status words, last marks the final one
// i_cfg_*   in   register writes: ISN, initial RTO, stream capacity
// Write, end, tick, empty and unknown words pass through accept, execute and finish.
// A fill sends one segment per cycle while o_out takes words, then a closing step unless its last
// segment carries SYN or FIN; it sends at most 48 segments per word.
// An ack beyond the next sequence number adds a compare step; any other ack adds compare,
// retire (one segment per cycle) and update steps and then runs a fill.
// Reset is synchronous, active low; the queue memory needs no clearing.
// Each cycle that o_out cannot take a word holds the sequencer in its fill or finish.
// Depends on tswr_pkg, tswr_in_if, tswr_out_if, tswr_ctrl, tswr_dp and the macros.
`include "tcp_sender_window_retransmit_core_macros.svh"
module tcp_sender_window_retransmit_core import tswr_pkg::*; #(
    parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF,
    parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    tswr_in_if.sink     i_in,
    tswr_out_if.source  o_out
);
    t_cmd cmd;
    t_sts sts;
    t_res res;
    logic in_ready, out_valid;

    tswr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    tswr_dp #(.MAX_PAYLOAD(MAX_PAYLOAD), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_op          (i_in.op),
        .i_byte_count  (i_in.byte_count),
        .i_ack_number  (i_in.ack_number),
        .i_adv_window  (i_in.adv_window),
        .i_elapsed_ms  (i_in.elapsed_ms),
        .i_out_ready   (o_out.ready),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .o_out_valid   (out_valid),
        .o_out         (res)
    );

    // Channel hookup.
    assign i_in.ready           = in_ready;
    assign o_out.valid          = out_valid;
    assign o_out.kind           = res.kind;
    assign o_out.seg_seqno      = res.seg_seqno;
    assign o_out.syn_flag       = res.syn_flag;
    assign o_out.fin_flag       = res.fin_flag;
    assign o_out.payload_length = res.payload_length;
    assign o_out.stream_offset  = res.stream_offset;
    assign o_out.outstanding    = res.outstanding;
    assign o_out.retx_count     = res.retx_count;
    assign o_out.accepted_bytes = res.accepted_bytes;
    assign o_out.last           = res.last;

    // Checks on the sequencer and datapath.
    `TSWR_ASSERT_NEXT(a_busy_after_take, cmd.take_in, !i_in.ready, "ready while a word is in work")
    `TSWR_ASSERT_NEXT(a_finish_loads, cmd.finish, o_out.valid, "finish left no result word")
    `TSWR_ASSERT_NOW(a_no_push_full, cmd.fill_step && sts.fill_go, !sts.fifo_full, "push into full queue")
endmodule
